/* rtl/core/bfp_pkg.sv */
// Shared types and constants for the bicolour LED framebuffer plotter.
// Holds the item and result structs, command codes, controller states
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package bfp_pkg;

  localparam int DISPLAY_WIDTH  = 32;
  localparam int DISPLAY_HEIGHT = 16;
  localparam int DRIVER_CHIPS   = 4;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = 8;

  localparam logic [2:0] CMD_PLOT_LIVE = 3'd0;
  localparam logic [2:0] CMD_PLOT_SNAP = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_TAKE_SNAP = 3'd3;
  localparam logic [2:0] CMD_DROP_SNAP = 3'd4;

  localparam logic [3:0] LIVE_TOP_BIT = 4'h8;
  localparam logic [3:0] LOW_NIBBLE   = 4'hF;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    logic [1:0]        color;
  } item_t;

  typedef struct packed {
    logic [2:0] chip_number;
    logic [5:0] word_address;
    logic [3:0] nibble_data;
    logic       is_write;
    logic [1:0] live_color;
    logic [1:0] snapshot_color;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RD_RED,
    ST_CAP_RED,
    ST_EXEC,
    ST_WR_RED,
    ST_OUT_GREEN,
    ST_OUT_RED,
    ST_OUT_ANSWER,
    ST_SW_RD,
    ST_SW_WR
  } state_t;

  typedef enum logic [1:0] {
    RD_GREEN,
    RD_RED,
    RD_SWEEP
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_GREEN,
    WR_RED,
    WR_SWEEP,
    WR_CLEAR
  } wr_sel_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_GREEN,
    LD_RED,
    LD_ANSWER
  } load_sel_t;

  typedef struct packed {
    logic      latch_item;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      cap_green;
    logic      cap_red;
    logic      wr_en;
    wr_sel_t   wr_sel;
    load_sel_t load_out;
    logic      idx_clr;
    logic      idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       on_display;
    logic       same_color;
    logic       idx_last;
  } dp_status_t;

endpackage

/* rtl/core/bfp_datapath.sv */
// Datapath of the framebuffer plotter: pixel store, item register,
// word registers, sweep index and result register. Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_datapath
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  dp_cmd_t    ctl,
  output dp_status_t status,
  output result_t    result
);

  logic [7:0] store [STORE_DEPTH];

  item_t               item_q;
  logic [7:0]          rd_data;
  logic [7:0]          gword;
  logic [7:0]          rword;
  logic [STORE_AW-1:0] idx;

  logic                on_display;
  logic [1:0]          chip;
  logic [5:0]          addr;
  logic [1:0]          shift;
  logic [STORE_AW-1:0] gi;
  logic [STORE_AW-1:0] ri;
  logic [3:0]          bit4;
  logic [7:0]          mask;
  logic [7:0]          g_new;
  logic [7:0]          r_new;
  logic [1:0]          live_cur;
  logic [1:0]          snap_cur;
  logic [STORE_AW-1:0] rd_addr;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          wr_data;
  logic [7:0]          sweep_data;

  // Pixel mapping: chip from the half column and half row, address from
  // column and upper/lower quad of the row, bit from the row within quad.
  always_comb begin
    on_display = (item_q.x_pos[7:5] == 3'd0) && (item_q.y_pos[7:4] == 4'd0);
    chip       = {item_q.y_pos[3], item_q.x_pos[4]};
    addr       = {1'b0, item_q.x_pos[3:0], item_q.y_pos[2]};
    shift      = item_q.y_pos[1:0];
    gi         = {chip, addr};
    ri         = {chip, 1'b1, addr[4:0]};
    bit4       = LIVE_TOP_BIT >> shift;
    mask       = (item_q.cmd == CMD_PLOT_SNAP) ? {bit4, 4'h0} : {4'h0, bit4};
    g_new      = item_q.color[0] ? (gword | mask) : (gword & ~mask);
    r_new      = item_q.color[1] ? (rword | mask) : (rword & ~mask);
    live_cur   = {|(rword[3:0] & bit4), |(gword[3:0] & bit4)};
    snap_cur   = {|(rword[7:4] & bit4), |(gword[7:4] & bit4)};
  end

  assign status.cmd        = item_q.cmd;
  assign status.on_display = on_display;
  assign status.same_color = (live_cur == item_q.color);
  assign status.idx_last   = (idx == STORE_AW'(STORE_DEPTH - 1));

  always_comb begin
    case (ctl.rd_sel)
      RD_GREEN: rd_addr = gi;
      RD_RED:   rd_addr = ri;
      RD_SWEEP: rd_addr = idx;
      default:  rd_addr = idx;
    endcase
  end

  // Take copies the live nibble up; drop clears the snapshot nibble.
  assign sweep_data = (item_q.cmd == CMD_TAKE_SNAP) ?
                      {rd_data[3:0], rd_data[3:0]} : {4'h0, rd_data[3:0]};

  always_comb begin
    case (ctl.wr_sel)
      WR_GREEN: begin
        wr_addr = gi;
        wr_data = g_new;
      end
      WR_RED: begin
        wr_addr = ri;
        wr_data = r_new;
      end
      WR_SWEEP: begin
        wr_addr = idx;
        wr_data = sweep_data;
      end
      default: begin
        wr_addr = idx;
        wr_data = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + STORE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      item_q <= item;
    end
    if (ctl.cap_green) begin
      gword <= rd_data;
    end
    if (ctl.cap_red) begin
      rword <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.load_out)
      LD_GREEN: begin
        result.chip_number    <= {1'b0, chip} + 3'd1;
        result.word_address   <= addr;
        result.nibble_data    <= g_new[3:0] & LOW_NIBBLE;
        result.is_write       <= 1'b1;
        result.live_color     <= 2'd0;
        result.snapshot_color <= 2'd0;
        result.last           <= 1'b0;
      end
      LD_RED: begin
        result.chip_number    <= {1'b0, chip} + 3'd1;
        result.word_address   <= {1'b1, addr[4:0]};
        result.nibble_data    <= r_new[3:0] & LOW_NIBBLE;
        result.is_write       <= 1'b1;
        result.live_color     <= 2'd0;
        result.snapshot_color <= 2'd0;
        result.last           <= 1'b1;
      end
      LD_ANSWER: begin
        result.chip_number    <= 3'd0;
        result.word_address   <= 6'd0;
        result.nibble_data    <= 4'd0;
        result.is_write       <= 1'b0;
        result.live_color     <= on_display ? live_cur : 2'd0;
        result.snapshot_color <= on_display ? snap_cur : 2'd0;
        result.last           <= 1'b1;
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

/* rtl/core/bfp_controller.sv */
// Controller state machine of the framebuffer plotter: sequences store
// reads, writes, sweeps and result transactions. Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_controller
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.rd_sel     = RD_GREEN;
    ctl.wr_sel     = WR_GREEN;
    ctl.load_out   = LD_NONE;
    item_ready     = 1'b0;
    result_valid   = 1'b0;

    case (state)
      ST_CLEAR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = WR_CLEAR;
        ctl.idx_inc = 1'b1;
        if (status.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready     = 1'b1;
        ctl.latch_item = item_valid;
        if (item_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.cmd)
          CMD_PLOT_LIVE, CMD_PLOT_SNAP: begin
            if (status.on_display) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_GREEN;
              state_next = ST_RD_RED;
            end else begin
              state_next = ST_IDLE;
            end
          end
          CMD_READ: begin
            if (status.on_display) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_GREEN;
              state_next = ST_RD_RED;
            end else begin
              ctl.load_out = LD_ANSWER;
              state_next   = ST_OUT_ANSWER;
            end
          end
          CMD_TAKE_SNAP, CMD_DROP_SNAP: begin
            ctl.idx_clr = 1'b1;
            state_next  = ST_SW_RD;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_RD_RED: begin
        ctl.cap_green = 1'b1;
        ctl.rd_en     = 1'b1;
        ctl.rd_sel    = RD_RED;
        state_next    = ST_CAP_RED;
      end
      ST_CAP_RED: begin
        ctl.cap_red = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.cmd == CMD_READ) begin
          ctl.load_out = LD_ANSWER;
          state_next   = ST_OUT_ANSWER;
        end else if (status.cmd == CMD_PLOT_LIVE && status.same_color) begin
          // unchanged colour: leave the store alone and send nothing
          state_next = ST_IDLE;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = WR_GREEN;
          state_next = ST_WR_RED;
        end
      end
      ST_WR_RED: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_RED;
        if (status.cmd == CMD_PLOT_LIVE) begin
          ctl.load_out = LD_GREEN;
          state_next   = ST_OUT_GREEN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT_GREEN: begin
        result_valid = 1'b1;
        if (result_ready) begin
          ctl.load_out = LD_RED;
          state_next   = ST_OUT_RED;
        end
      end
      ST_OUT_RED, ST_OUT_ANSWER: begin
        result_valid = 1'b1;
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_SW_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_SWEEP;
        state_next = ST_SW_WR;
      end
      ST_SW_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = WR_SWEEP;
        ctl.idx_inc = 1'b1;
        state_next  = status.idx_last ? ST_IDLE : ST_SW_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("item taken while a result transaction is pending");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item taken before the store clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second item taken while one is at work");

  a_red_follows_green: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_GREEN && result_ready) |=> (state == ST_OUT_RED))
    else $error("red write frame did not follow the green one");

  a_write_only_in_work: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> !item_ready)
    else $error("store written while idle");
`endif

endmodule

/* rtl/core/bicolor_led_framebuffer_plotter.sv */
// Top level of the bicolour LED matrix framebuffer plotter.
// Joins bfp_controller and bfp_datapath; depends on bfp_pkg.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one command at a time.
//   result channel (result_valid/result_ready/result) gives write frames
//   (green word then red word, last on the red one) and read answers.
// Steps, from acceptance of an item to the earliest acceptance of the next:
//   plot live/snapshot on the display: decode (reads green), read red,
//   capture red, execute (writes green), write red; a live plot that
//   keeps the colour goes back to idle from execute; a live plot that
//   changes a colour then sends green and red write frames, red once
//   green is taken. read pixel: the same steps up to execute, then the
//   answer (off the display, decode loads it). Off-display plots and
//   unknown commands go back to idle from decode.
//   take/drop snapshot: a read state then a write state per store entry.
// Reset: a clearing pass writes zero to all 256 store entries, one per
// cycle, so item_ready stays low until the pass is done.
// A stalled receiver holds the result register and the block takes no
// new item until every result of the current one has been taken.
`timescale 1ns / 1ps

module bicolor_led_framebuffer_plotter
  import bfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  dp_cmd_t    ctl;
  dp_status_t status;

  bfp_controller u_controller (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .ctl          (ctl)
  );

  bfp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .status (status),
    .result (result)
  );

endmodule

/* tb/bicolor_led_framebuffer_plotter_test.sv */
// Self-checking test of the bicolour LED framebuffer plotter.
// Drives commands and checks write frames and read answers against a local shadow store.
// Depends on bfp_pkg and bicolor_led_framebuffer_plotter.
`timescale 1ns / 1ps

module bicolor_led_framebuffer_plotter_test;
  import bfp_pkg::*;

  localparam int CHIP_COLS   = DISPLAY_WIDTH / 2;
  localparam int CHIP_ROWS   = DISPLAY_HEIGHT / 2;
  localparam int PLANE_WORDS = 64;
  localparam int RED_OFFSET  = 32;
  localparam int MAX_WAIT    = 14;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;

  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;

  localparam logic [1:0] COLOR_BLACK  = 2'd0;
  localparam logic [1:0] COLOR_GREEN  = 2'd1;
  localparam logic [1:0] COLOR_RED    = 2'd2;
  localparam logic [1:0] COLOR_ORANGE = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic [7:0] shadow_fb [STORE_DEPTH];
  result_t    results_due [$];
  result_t    want;
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         sender_idles = 1'b1;
  bit         receiver_idles = 1'b1;

  bicolor_led_framebuffer_plotter u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait(input bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic item_t pack_item(input logic [2:0] cmd, input int col, input int row,
                                      input logic [1:0] color);
    item_t it;
    it.cmd   = cmd;
    it.x_pos = col[7:0];
    it.y_pos = row[7:0];
    it.color = color;
    return it;
  endfunction

  // Set or clear one pixel bit in both colour planes.
  function automatic void paint(input int gi, input int ri, input logic [7:0] mask,
                                input logic [1:0] color);
    if (color[0]) shadow_fb[gi] |= mask; else shadow_fb[gi] &= ~mask;
    if (color[1]) shadow_fb[ri] |= mask; else shadow_fb[ri] &= ~mask;
  endfunction

  // Update the shadow store for one command and queue the results it causes.
  function automatic void apply_command(input item_t it);
    int         col, row, chip, addr, gi, ri;
    logic       on_disp;
    logic [7:0] live_bit, snap_bit;
    logic [1:0] live_now, snap_now;
    result_t    r;
    col = $signed(it.x_pos);
    row = $signed(it.y_pos);
    on_disp = col >= 0 && col < DISPLAY_WIDTH && row >= 0 && row < DISPLAY_HEIGHT;
    chip = 0;
    addr = 0;
    live_bit = 8'(LIVE_TOP_BIT);
    if (on_disp) begin
      chip = col / CHIP_COLS + (row >= CHIP_ROWS ? 2 : 0);
      addr = ((col % CHIP_COLS) << 1) + ((row % CHIP_ROWS) >> 2);
      live_bit = 8'(LIVE_TOP_BIT) >> (row % 4);
    end
    snap_bit = live_bit << 4;
    gi = chip * PLANE_WORDS + addr;
    ri = gi + RED_OFFSET;
    live_now = {|(shadow_fb[ri] & live_bit), |(shadow_fb[gi] & live_bit)};
    snap_now = {|(shadow_fb[ri] & snap_bit), |(shadow_fb[gi] & snap_bit)};
    r = '0;
    case (it.cmd)
      CMD_PLOT_LIVE: begin
        if (on_disp && live_now != it.color) begin
          paint(gi, ri, live_bit, it.color);
          r.is_write     = 1'b1;
          r.chip_number  = 3'(chip + 1);
          r.word_address = 6'(addr);
          r.nibble_data  = shadow_fb[gi][3:0] & LOW_NIBBLE;
          results_due.push_back(r);
          r.word_address = 6'(addr + RED_OFFSET);
          r.nibble_data  = shadow_fb[ri][3:0] & LOW_NIBBLE;
          r.last         = 1'b1;
          results_due.push_back(r);
        end
      end
      CMD_PLOT_SNAP: begin
        if (on_disp) paint(gi, ri, snap_bit, it.color);
      end
      CMD_READ: begin
        r.live_color     = on_disp ? live_now : COLOR_BLACK;
        r.snapshot_color = on_disp ? snap_now : COLOR_BLACK;
        r.last           = 1'b1;
        results_due.push_back(r);
      end
      CMD_TAKE_SNAP: begin
        for (int i = 0; i < STORE_DEPTH; i++) shadow_fb[i] = {2{shadow_fb[i][3:0]}};
      end
      CMD_DROP_SNAP: begin
        for (int i = 0; i < STORE_DEPTH; i++) shadow_fb[i][7:4] = 4'h0;
      end
      default: ;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(sender_idles);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    apply_command(it);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  function automatic item_t random_item(input bit tight);
    item_t it;
    int    pick;
    pick     = $urandom_range(0, 99);
    it.color = 2'($urandom_range(COLOR_BLACK, COLOR_ORANGE));
    it.x_pos = tight ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, DISPLAY_WIDTH - 1));
    it.y_pos = 8'($urandom_range(0, DISPLAY_HEIGHT - 1));
    if (pick < 42)      it.cmd = CMD_PLOT_LIVE;
    else if (pick < 57) it.cmd = CMD_PLOT_SNAP;
    else if (pick < 86) it.cmd = CMD_READ;
    else if (pick < 88) it.cmd = CMD_TAKE_SNAP;
    else if (pick < 90) it.cmd = CMD_DROP_SNAP;
    else if (pick < 92) it.cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
    else begin
      // off-display noise over the full coordinate range
      it.cmd   = 3'($urandom_range(CMD_PLOT_LIVE, CMD_READ));
      it.x_pos = 8'($urandom());
      it.y_pos = 8'($urandom());
    end
    return it;
  endfunction

  task automatic run_traffic(input int count, input bit tight, input bit idles,
                             input int pause_every);
    sender_idles   = idles;
    receiver_idles = idles;
    for (int i = 0; i < count; i++) begin
      send_item(random_item(tight));
      if (pause_every > 0 && i % pause_every == pause_every - 1) hold_until_drained();
    end
  endtask

  task automatic test_corner_cases();
    send_item(pack_item(CMD_PLOT_LIVE, 0, 0, COLOR_GREEN));
    send_item(pack_item(CMD_PLOT_LIVE, 31, 15, COLOR_RED));
    send_item(pack_item(CMD_PLOT_LIVE, 31, 0, COLOR_ORANGE));
    send_item(pack_item(CMD_PLOT_LIVE, 0, 15, COLOR_ORANGE));
    send_item(pack_item(CMD_PLOT_LIVE, 0, 0, COLOR_GREEN));
    send_item(pack_item(CMD_PLOT_LIVE, 0, 1, COLOR_RED));
    send_item(pack_item(CMD_READ, 0, 0, COLOR_BLACK));
    send_item(pack_item(CMD_READ, 31, 15, COLOR_ORANGE));
    send_item(pack_item(CMD_PLOT_LIVE, -1, 0, COLOR_GREEN));
    send_item(pack_item(CMD_PLOT_LIVE, 32, 5, COLOR_RED));
    send_item(pack_item(CMD_PLOT_LIVE, 3, 16, COLOR_ORANGE));
    send_item(pack_item(CMD_PLOT_SNAP, -128, 127, COLOR_ORANGE));
    send_item(pack_item(CMD_READ, -128, -128, COLOR_BLACK));
    send_item(pack_item(CMD_READ, 127, -1, COLOR_ORANGE));
    send_item(pack_item(CMD_PLOT_SNAP, 0, 0, COLOR_RED));
    send_item(pack_item(CMD_READ, 0, 0, COLOR_BLACK));
    send_item(pack_item(CMD_TAKE_SNAP, 0, 0, COLOR_BLACK));
    send_item(pack_item(CMD_READ, 31, 15, COLOR_BLACK));
    send_item(pack_item(CMD_PLOT_LIVE, 31, 15, COLOR_BLACK));
    send_item(pack_item(CMD_READ, 31, 15, COLOR_BLACK));
    send_item(pack_item(CMD_DROP_SNAP, 0, 0, COLOR_BLACK));
    send_item(pack_item(CMD_READ, 0, 0, COLOR_BLACK));
    send_item(pack_item(CMD_FIRST_UNKNOWN, 5, 5, COLOR_ORANGE));
    send_item(pack_item(CMD_LAST_UNKNOWN, 0, 0, COLOR_GREEN));
    send_item(pack_item(CMD_PLOT_LIVE, 0, 0, COLOR_BLACK));
  endtask

  task automatic test_mixed_traffic();
    run_traffic(600, 1'b0, 1'b1, 0);
  endtask

  task automatic test_back_to_back();
    run_traffic(300, 1'b0, 1'b0, 0);
  endtask

  task automatic test_same_word_updates();
    run_traffic(300, 1'b1, 1'b1, 0);
  endtask

  task automatic test_drained_pauses();
    run_traffic(450, 1'b0, 1'b1, 50);
  endtask

  // Result receiver: random stall before each transaction.
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait(receiver_idles);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  task automatic flag_field(input string name, input int exp_v, input int got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, result);
      end else begin
        want = results_due.pop_front();
        flag_field("chip_number", want.chip_number, result.chip_number);
        flag_field("word_address", want.word_address, result.word_address);
        flag_field("nibble_data", want.nibble_data, result.nibble_data);
        flag_field("is_write", want.is_write, result.is_write);
        flag_field("live_color", want.live_color, result.live_color);
        flag_field("snapshot_color", want.snapshot_color, result.snapshot_color);
        flag_field("last", want.last, result.last);
      end
    end
  end

  // Drop out if no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bicolor_led_framebuffer_plotter_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) shadow_fb[i] = 8'h00;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_corner_cases();
    test_mixed_traffic();
    test_back_to_back();
    test_same_word_updates();
    test_drained_pauses();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bicolor_led_framebuffer_plotter_test OK");
    end else begin
      $display("bicolor_led_framebuffer_plotter_test NOT OK");
    end
    $finish;
  end

endmodule
